### hdl/explut_pkg.sv
// ----------------------------------------------------------------------------
// explut_pkg
// Shared constants, beat types and the exp(n) table for the exponential block.
// ----------------------------------------------------------------------------
package explut_pkg;

   localparam int IN_FRAC_BITS  = 16;
   localparam int OUT_FRAC_BITS = 24;
   localparam int EXP_LIMIT     = 16;

   localparam int X_W       = 24;
   localparam int EXP_W     = 48;
   localparam int POLY_BITS = 30;
   localparam int ROM_W     = 64;
   localparam int HALF_W    = ROM_W / 2;
   localparam int ROM_SIZE  = 2 * EXP_LIMIT + 1;
   localparam int IDX_W     = $clog2(ROM_SIZE);
   localparam int NMAG_W    = X_W - IN_FRAC_BITS + 1;

   // polynomial datapath widths
   localparam int EQ_W   = POLY_BITS + 1;
   localparam int V_W    = POLY_BITS - 1;
   localparam int P3_W   = 2 * V_W;
   localparam int M1_W   = 2 * EQ_W;
   localparam int T1_W   = POLY_BITS + 3;
   localparam int M2_W   = EQ_W + T1_W;
   localparam int T2_W   = POLY_BITS + 4;
   localparam int T_W    = POLY_BITS + 2;
   localparam int PROD_W = ROM_W + T_W;

   // divide by three as multiply by reciprocal, exact for values below 2^(POLY_BITS-1)
   localparam int DIV3_SHIFT = POLY_BITS;
   localparam logic [V_W-1:0] DIV3_MUL = V_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);

   localparam int RES_SHIFT = HALF_W + POLY_BITS - OUT_FRAC_BITS;

   typedef struct packed {
      logic signed [X_W-1:0] x_in;
      logic                  last_in;
   } explut_req_type;

   typedef struct packed {
      logic [EXP_W-1:0] exp_out;
      logic             last_out;
   } explut_rsp_type;

   typedef logic [ROM_SIZE-1:0][ROM_W-1:0] exp_rom_type;

   // exp(n) in Q32.32 for n in [-EXP_LIMIT, EXP_LIMIT], built by chained products
   function automatic exp_rom_type exp_rom_build();
      logic [ROM_W-1:0]   term;
      logic [ROM_W-1:0]   e_pos;
      logic [ROM_W-1:0]   e_neg;
      logic [ROM_W-1:0]   p;
      logic [ROM_W-1:0]   q;
      logic [2*ROM_W-1:0] wide;
      exp_rom_type        rom;
      rom   = '0;
      term  = 64'd1 << 62;
      e_pos = '0;
      e_neg = '0;
      for (int k = 0; k <= 27; k++) begin
         e_pos = e_pos + term;
         if ((k & 1) != 0) begin
            e_neg = e_neg - term;
         end else begin
            e_neg = e_neg + term;
         end
         term = term / 64'(k + 1);
      end
      p = 64'd1 << 32;
      q = 64'd1 << 63;
      rom[EXP_LIMIT] = p;
      for (int k = 1; k <= EXP_LIMIT; k++) begin
         wide = 128'(p) * 128'(e_pos) + (128'd1 << 61);
         p    = wide[125:62];
         wide = 128'(q) * 128'(e_neg) + (128'd1 << 61);
         q    = wide[125:62];
         rom[EXP_LIMIT + k] = p;
         wide = 128'(q) + (128'd1 << 30);
         rom[EXP_LIMIT - k] = wide[94:31];
      end
      return rom;
   endfunction

   localparam exp_rom_type EXP_ROM = exp_rom_build();

endpackage

### hdl/exp_lut_cubic_taylor.sv
// ----------------------------------------------------------------------------
// exp_lut_cubic_taylor
// Streaming fixed-point exp(x): table of exp(n) times a cubic Taylor term.
// ----------------------------------------------------------------------------
// One beat in, one beat out. The block is an eleven-stage pipeline that takes
// a new beat every clock cycle while req_stall is low. Its stages cover the
// argument rounding, the two polynomial multiplies, the divide by three and
// the 64x32 table product cut into two 32x32 halves. Each stage
// holds its own valid bit and moves whenever the stage after it is empty or
// moving, so bubbles close up under rsp_stall and req_stall rises only when
// every stage holds a beat. Inputs above EXP_LIMIT return exp(EXP_LIMIT),
// inputs that round below -EXP_LIMIT return zero, and the output saturates
// at all ones. last_in rides along unchanged.
module exp_lut_cubic_taylor
   import explut_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  explut_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output explut_rsp_type rsp_data
);

   localparam int NSTG = 11;

   localparam logic [IDX_W-1:0] IDX_MID = IDX_W'(EXP_LIMIT);
   localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(2 * EXP_LIMIT);
   localparam logic [31:0]      X_LIMIT = 32'(EXP_LIMIT) << IN_FRAC_BITS;

   localparam logic signed [EQ_W-1:0] C_HALF  = EQ_W'(1) << (POLY_BITS - 1);
   localparam logic signed [M1_W-1:0] M1_RND  = M1_W'(1) << (POLY_BITS - 1);
   localparam logic signed [M2_W-1:0] M2_RND  = M2_W'(1) << (POLY_BITS - 1);
   localparam logic signed [T1_W-1:0] T1_ONE  = T1_W'(1) << POLY_BITS;
   localparam logic signed [T2_W-1:0] T2_ONE  = T2_W'(1) << POLY_BITS;
   localparam logic [ROM_W:0]         LO_RND  = (ROM_W + 1)'(1) << (RES_SHIFT - 1);

   typedef struct packed {
      logic last;
      logic zero;
   } side_type;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] adv;

   side_type side_ff [0:NSTG-2];

   // stage 0: rounding of the argument
   logic signed [X_W-1:0] x0_ff;
   logic                  over0_ff;
   logic [NMAG_W-1:0]     nmag0_ff;
   logic                  over_in;
   logic [NMAG_W-1:0]     nmag_in;
   logic [X_W:0]          ax;
   logic [X_W:0]          nround;

   // stage 1: fraction and table index
   logic [IN_FRAC_BITS-1:0] emag1_ff;
   logic                    eneg1_ff;
   logic [IDX_W-1:0]        idx1_ff;
   logic [IN_FRAC_BITS-1:0] emag_in;
   logic                    eneg_in;
   logic [IDX_W-1:0]        idx_in;
   logic                    zero_in;
   logic                    sgn0;
   logic [X_W:0]            nsh;
   logic [X_W:0]            xe;
   logic [X_W:0]            efull;
   logic [X_W:0]            eabs;

   // stage 2: divide by three, scaled fraction, table read
   logic [P3_W-1:0]         p3_ff;
   logic [P3_W-1:0]         p3_in;
   logic signed [EQ_W-1:0]  eq_ff [2:5];
   logic signed [EQ_W-1:0]  eq_in;
   logic [ROM_W-1:0]        rom_ff [2:8];
   logic [ROM_W-1:0]        rom_in;
   logic [V_W-1:0]          v;
   logic [EQ_W-1:0]         eq_mag;

   // stages 3 to 7: Horner steps
   logic signed [EQ_W-1:0]  c3_ff;
   logic signed [EQ_W-1:0]  c_in;
   logic [P3_W-DIV3_SHIFT-1:0] q3;
   logic signed [M1_W-1:0]  m1_ff;
   logic signed [M1_W-1:0]  m1_in;
   logic signed [T1_W-1:0]  t1_ff;
   logic signed [T1_W-1:0]  t1_in;
   logic signed [M2_W-1:0]  m2_ff;
   logic signed [M2_W-1:0]  m2_in;
   logic signed [T2_W-1:0]  t2;
   logic [T_W-1:0]          t7_ff;
   logic [T_W-1:0]          t_in;

   // stages 8 to 10: table factor product and output
   logic [T_W-1:0]          t8_ff;
   logic [ROM_W-1:0]        plo8_ff;
   logic [ROM_W-1:0]        plo_in;
   logic [ROM_W-1:0]        phi9_ff;
   logic [ROM_W-1:0]        phi_in;
   logic [ROM_W:0]          loadj9_ff;
   logic [ROM_W:0]          loadj_in;
   logic [PROD_W-1:0]       full;
   logic                    sat;
   explut_rsp_type          rsp_ff;
   explut_rsp_type          rsp_in;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp_data  = rsp_ff;

   always_comb begin
      // stage 0
      if (req_data.x_in[X_W-1]) begin
         ax = (X_W + 1)'(0) - {req_data.x_in[X_W-1], req_data.x_in};
      end else begin
         ax = {1'b0, req_data.x_in};
      end
      nround  = ax + ((X_W + 1)'(1) << (IN_FRAC_BITS - 1));
      nmag_in = nround[X_W:IN_FRAC_BITS];
      over_in = !req_data.x_in[X_W-1] && (32'(req_data.x_in[X_W-2:0]) > X_LIMIT);

      // stage 1
      sgn0  = x0_ff[X_W-1];
      nsh   = (X_W + 1)'(nmag0_ff) << IN_FRAC_BITS;
      xe    = {x0_ff[X_W-1], x0_ff};
      efull = sgn0 ? xe + nsh : xe - nsh;
      eabs  = efull[X_W] ? (X_W + 1)'(0) - efull : efull;
      emag_in = over0_ff ? '0 : eabs[IN_FRAC_BITS-1:0];
      eneg_in = !over0_ff && efull[X_W];
      zero_in = sgn0 && (32'(nmag0_ff) > 32'(EXP_LIMIT));
      if (over0_ff) begin
         idx_in = IDX_TOP;
      end else if (sgn0) begin
         idx_in = IDX_MID - IDX_W'(nmag0_ff);
      end else begin
         idx_in = IDX_MID + IDX_W'(nmag0_ff);
      end

      // stage 2: c = 1/2 + e/6 needs round(eq/6) = floor((|e|*2^k + 1)/3)
      v      = (V_W'(emag1_ff) << (POLY_BITS - IN_FRAC_BITS - 1)) + V_W'(1);
      p3_in  = P3_W'(v) * P3_W'(DIV3_MUL);
      eq_mag = EQ_W'(emag1_ff) << (POLY_BITS - IN_FRAC_BITS);
      eq_in  = eneg1_ff ? EQ_W'(0) - eq_mag : eq_mag;
      rom_in = EXP_ROM[idx1_ff];

      // stage 3
      q3   = p3_ff[P3_W-1:DIV3_SHIFT];
      c_in = eq_ff[2][EQ_W-1] ? C_HALF - EQ_W'(q3) : C_HALF + EQ_W'(q3);

      // stages 4 to 7
      m1_in = eq_ff[3] * c3_ff;
      t1_in = T1_ONE + T1_W'((m1_ff + M1_RND) >>> POLY_BITS);
      m2_in = eq_ff[5] * t1_ff;
      t2    = T2_ONE + T2_W'((m2_ff + M2_RND) >>> POLY_BITS);
      t_in  = t2[T2_W-1] ? '0 : t2[T_W-1:0];

      // stages 8 and 9: split 64x32 product
      plo_in   = ROM_W'(rom_ff[7][HALF_W-1:0]) * ROM_W'(t7_ff);
      phi_in   = ROM_W'(rom_ff[8][ROM_W-1:HALF_W]) * ROM_W'(t8_ff);
      loadj_in = (ROM_W + 1)'(plo8_ff) + LO_RND;

      // stage 10: recombine, round, saturate
      full = {phi9_ff, HALF_W'(0)} + PROD_W'(loadj9_ff);
      sat  = |full[PROD_W-1:RES_SHIFT+EXP_W];
      rsp_in.last_out = side_ff[NSTG-2].last;
      if (side_ff[NSTG-2].zero) begin
         rsp_in.exp_out = '0;
      end else if (sat) begin
         rsp_in.exp_out = '1;
      end else begin
         rsp_in.exp_out = full[RES_SHIFT+EXP_W-1:RES_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x0_ff            <= req_data.x_in;
         over0_ff         <= over_in;
         nmag0_ff         <= nmag_in;
         side_ff[0].last  <= req_data.last_in;
         side_ff[0].zero  <= 1'b0;
      end
      if (adv[1]) begin
         emag1_ff         <= emag_in;
         eneg1_ff         <= eneg_in;
         idx1_ff          <= idx_in;
         side_ff[1].last  <= side_ff[0].last;
         side_ff[1].zero  <= zero_in;
      end
      for (int i = 2; i < NSTG - 1; i++) begin
         if (adv[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
      if (adv[2]) begin
         p3_ff     <= p3_in;
         eq_ff[2]  <= eq_in;
         rom_ff[2] <= rom_in;
      end
      for (int i = 3; i <= 5; i++) begin
         if (adv[i]) begin
            eq_ff[i] <= eq_ff[i-1];
         end
      end
      for (int i = 3; i <= 8; i++) begin
         if (adv[i]) begin
            rom_ff[i] <= rom_ff[i-1];
         end
      end
      if (adv[3]) begin
         c3_ff <= c_in;
      end
      if (adv[4]) begin
         m1_ff <= m1_in;
      end
      if (adv[5]) begin
         t1_ff <= t1_in;
      end
      if (adv[6]) begin
         m2_ff <= m2_in;
      end
      if (adv[7]) begin
         t7_ff <= t_in;
      end
      if (adv[8]) begin
         plo8_ff <= plo_in;
         t8_ff   <= t7_ff;
      end
      if (adv[9]) begin
         phi9_ff   <= phi_in;
         loadj9_ff <= loadj_in;
      end
      if (adv[10]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### hdl/explut_check.sv
// ----------------------------------------------------------------------------
// explut_check
// Port-level checks for exp_lut_cubic_taylor, bound to the top level.
// ----------------------------------------------------------------------------
module explut_check
   import explut_pkg::*;
(
   input logic           clock,
   input logic           reset,
   input logic           req_valid,
   input logic           req_stall,
   input explut_req_type req_data,
   input logic           rsp_valid,
   input logic           rsp_stall,
   input explut_rsp_type rsp_data
);

   // a held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // input backs up only when a result beat is held by rsp_stall
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without a stalled rsp beat");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid right after reset");

   // an empty output stage cannot hold input back
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall while output empty");

endmodule

bind exp_lut_cubic_taylor explut_check u_explut_check (.*);
